// ===== src/tp20_pkg.sv =====
// ----------------------------------------------------------------------------
// tp20_pkg
// Shared types and constants for the TP2.0 receive reassembler.
// ----------------------------------------------------------------------------
package tp20_pkg;

  localparam logic [2:0]  ST_OK        = 3'd0;
  localparam logic [2:0]  ST_BAD_OP    = 3'd1;
  localparam logic [2:0]  ST_SEQ_ERR   = 3'd2;
  localparam logic [2:0]  ST_SHORT_FF  = 3'd3;
  localparam logic [2:0]  ST_OVERLONG  = 3'd4;
  localparam logic [2:0]  ST_MSG_SHORT = 3'd5;

  localparam logic [14:0] LEN_MASK     = 15'h7FFF;
  localparam logic [7:0]  ACK_BASE     = 8'hB0;
  localparam logic [3:0]  MAX_BYTES    = 4'd8;
  localparam logic [3:0]  FIRST_START  = 4'd3;
  localparam logic [3:0]  NEXT_START   = 4'd1;
  localparam logic [3:0]  MAX_OPCODE   = 4'd3;

  // one frame's worth of results, handed from decode to the serializer
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      n;
    logic [3:0]      start;
    logic [2:0]      status;
    logic            done;
    logic            ack_req;
    logic [7:0]      ack_byte;
    logic [14:0]     length;
  } job_t;

endpackage

// ===== src/tp20_receive_reassembler.sv =====
// ----------------------------------------------------------------------------
// tp20_receive_reassembler
// TP2.0 receive path: validates data frames and streams the message
// payload bytes, each frame closed by a status result.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   action, frame_len, byte_0 .. byte_7
//  out      out_valid / out_stall kind, payload_byte, status, message_done,
//                                 message_length, ack_request, ack_byte, last
//
//  A frame with k payload bytes gives k+1 results (up to 8), one per cycle
//  while out_stall is low. First result passes pend and act after accept;
//  a frame that gives results stalls the input while its job is in pend.
//  Channel-open and empty frames give no result and do not stall the input.
//  Checks and state update at accept.
//  Synchronous reset returns the message state to awaiting a first frame.
// ----------------------------------------------------------------------------
module tp20_receive_reassembler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [3:0]  frame_len,
  input  logic [7:0]  byte_0,
  input  logic [7:0]  byte_1,
  input  logic [7:0]  byte_2,
  input  logic [7:0]  byte_3,
  input  logic [7:0]  byte_4,
  input  logic [7:0]  byte_5,
  input  logic [7:0]  byte_6,
  input  logic [7:0]  byte_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  status,
  output logic        message_done,
  output logic [14:0] message_length,
  output logic        ack_request,
  output logic [7:0]  ack_byte,
  output logic        last
);
  import tp20_pkg::*;

  logic            accept;
  logic            job_valid;
  logic            full;
  job_t            job;
  logic [7:0][7:0] frame_bytes;

  assign frame_bytes = {byte_7, byte_6, byte_5, byte_4, byte_3, byte_2, byte_1, byte_0};
  assign in_stall    = full;
  assign accept      = in_valid && !in_stall;

  tp20_rx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .frame_len   (frame_len),
    .frame_bytes (frame_bytes),
    .job_valid   (job_valid),
    .job         (job)
  );

  tp20_rx_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (job_valid),
    .job            (job),
    .full           (full),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .status         (status),
    .message_done   (message_done),
    .message_length (message_length),
    .ack_request    (ack_request),
    .ack_byte       (ack_byte),
    .last           (last)
  );

endmodule

// ===== src/tp20_rx_front.sv =====
// ----------------------------------------------------------------------------
// tp20_rx_front
// Frame decode and message state: checks opcode, sequence and length on
// each accepted non-empty data frame and builds the result job for the serializer.
// ----------------------------------------------------------------------------
module tp20_rx_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              action,
  input  logic [3:0]        frame_len,
  input  logic [7:0][7:0]   frame_bytes,
  output logic              job_valid,
  output tp20_pkg::job_t    job
);
  import tp20_pkg::*;

  logic        awaiting_first, awaiting_first_next;
  logic [3:0]  expected_seq, expected_seq_next;
  logic [14:0] declared_length, declared_length_next;
  logic [15:0] received_count, received_count_next;

  logic [3:0]  n;
  logic [3:0]  opcode, seq;
  logic [14:0] dl;
  logic [15:0] rc, rc_new;
  logic [3:0]  st;
  logic [3:0]  seq_inc;
  logic        err;

  always_comb begin
    n       = (frame_len > MAX_BYTES) ? MAX_BYTES : frame_len;
    opcode  = frame_bytes[0][7:4];
    seq     = frame_bytes[0][3:0];
    seq_inc = expected_seq + 4'd1;
    dl      = awaiting_first ? (15'({frame_bytes[1], frame_bytes[2]}) & LEN_MASK)
                             : declared_length;
    rc      = awaiting_first ? 16'd0 : received_count;
    st      = awaiting_first ? FIRST_START : NEXT_START;
    rc_new  = rc + {12'd0, n - st};

    awaiting_first_next  = awaiting_first;
    expected_seq_next    = expected_seq;
    declared_length_next = declared_length;
    received_count_next  = received_count;
    err                  = 1'b0;

    job.bytes    = frame_bytes;
    job.n        = n;
    job.start    = st;
    job.status   = ST_OK;
    job.done     = 1'b0;
    job.ack_req  = 1'b0;
    job.ack_byte = ACK_BASE | {4'd0, expected_seq};
    job.length   = declared_length;

    job_valid = accept && !action && (n != 4'd0);

    if (action) begin
      awaiting_first_next  = 1'b1;
      expected_seq_next    = 4'd0;
      declared_length_next = 15'd0;
      received_count_next  = 16'd0;
    end else if (n != 4'd0) begin
      if (awaiting_first && (n < FIRST_START)) begin
        err        = 1'b1;
        job.status = ST_SHORT_FF;
      end else begin
        declared_length_next = dl;
        job.length           = dl;
        if (!awaiting_first && (rc > {1'b0, dl})) begin
          err        = 1'b1;
          job.status = ST_OVERLONG;
        end else if (opcode > MAX_OPCODE) begin
          err        = 1'b1;
          job.status = ST_BAD_OP;
        end else begin
          expected_seq_next = seq_inc;
          job.ack_byte      = ACK_BASE | {4'd0, seq_inc};
          if (seq != expected_seq) begin
            err        = 1'b1;
            job.status = ST_SEQ_ERR;
          end else if (opcode[0]) begin
            awaiting_first_next = 1'b1;
            received_count_next = 16'd0;
            if (rc_new < {1'b0, dl}) begin
              job.status = ST_MSG_SHORT;
            end else begin
              job.done    = 1'b1;
              job.ack_req = !opcode[1];
            end
          end else begin
            awaiting_first_next = 1'b0;
            received_count_next = rc_new;
            job.ack_req         = !opcode[1];
          end
        end
      end
      if (err) begin
        awaiting_first_next = 1'b1;
        received_count_next = 16'd0;
        job.start           = n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first  <= 1'b1;
      expected_seq    <= 4'd0;
      declared_length <= 15'd0;
      received_count  <= 16'd0;
    end else if (accept) begin
      awaiting_first  <= awaiting_first_next;
      expected_seq    <= expected_seq_next;
      declared_length <= declared_length_next;
      received_count  <= received_count_next;
    end
  end

endmodule

// ===== src/tp20_rx_emit.sv =====
// ----------------------------------------------------------------------------
// tp20_rx_emit
// Two-deep job buffer and result serializer: payload bytes one per cycle
// while out_stall is low, then the frame status result.
// ----------------------------------------------------------------------------
module tp20_rx_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  tp20_pkg::job_t    job,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              kind,
  output logic [7:0]        payload_byte,
  output logic [2:0]        status,
  output logic              message_done,
  output logic [14:0]       message_length,
  output logic              ack_request,
  output logic [7:0]        ack_byte,
  output logic              last
);
  import tp20_pkg::*;

  job_t       pend, act;
  logic       pend_valid, act_valid;
  logic [3:0] cur;
  logic       in_payload, take, fin, load;

  always_comb begin
    in_payload     = cur < act.n;
    take           = act_valid && !out_stall;
    fin            = take && !in_payload;
    load           = pend_valid && (!act_valid || fin);
    full           = pend_valid;

    out_valid      = act_valid;
    kind           = !in_payload;
    payload_byte   = in_payload ? act.bytes[cur[2:0]] : 8'd0;
    status         = in_payload ? ST_OK : act.status;
    message_done   = in_payload ? 1'b0 : act.done;
    message_length = act.length;
    ack_request    = in_payload ? 1'b0 : act.ack_req;
    ack_byte       = in_payload ? 8'd0 : act.ack_byte;
    last           = !in_payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      act_valid  <= 1'b0;
    end else begin
      if (job_valid) begin
        pend_valid <= 1'b1;
      end else if (load) begin
        pend_valid <= 1'b0;
      end
      if (load) begin
        act_valid <= 1'b1;
      end else if (fin) begin
        act_valid <= 1'b0;
      end
    end
    if (job_valid) begin
      pend <= job;
    end
    if (load) begin
      act <= pend;
      cur <= pend.start;
    end else if (take) begin
      cur <= cur + 4'd1;
    end
  end

  a_cur_bound: assert property (@(posedge clk) disable iff (rst)
    act_valid |-> (cur <= act.n))
    else $error("serializer index ran past frame length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(pend_valid && job_valid))
    else $error("new job while buffer full");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (fin && !pend_valid) |=> !act_valid)
    else $error("results continued after final status");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (act_valid && last) |-> kind)
    else $error("last marked on a payload result");

endmodule
